>>> rtl/dalt_pkg.sv
`default_nettype none
package dalt_pkg;

  // field widths
  localparam int RAW_W = 12;
  localparam int PCT_W = 7;
  localparam int POS_W = 8;
  localparam int STEP_W = 3;
  localparam int THR_W = 7;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_LIGHT_THR = 2'd0;
  localparam logic [1:0] REG_RAIN_THR = 2'd1;
  localparam logic [1:0] REG_TRAVEL_LIMIT = 2'd2;

  // reset values
  localparam logic [THR_W-1:0] LIGHT_THR_RST = 7'd20;
  localparam logic [THR_W-1:0] RAIN_THR_RST = 7'd30;
  localparam logic [POS_W-1:0] TRAVEL_LIMIT_RST = 8'd200;
  localparam logic [POS_W-1:0] POS_RST = 8'd100;

  localparam int PHASES_PER_COUNT_DEF = 8;
  localparam logic [PCT_W-1:0] DEADBAND = 7'd10;

  // item kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // axis mode, also used as the drive code
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [THR_W-1:0] light_thr;
    logic [THR_W-1:0] rain_thr;
    logic [POS_W-1:0] travel_limit;
  } cfg_t;

  typedef struct packed {
    logic [PCT_W-1:0] left_pct;
    logic [PCT_W-1:0] right_pct;
    logic [PCT_W-1:0] up_pct;
    logic [PCT_W-1:0] down_pct;
    mode_t            horiz_mode;
    mode_t            vert_mode;
  } dec_t;

  typedef struct packed {
    mode_t             mode;
    mode_t             drive;
    logic [STEP_W-1:0] phase;
    logic [POS_W-1:0]  pos;
  } axis_res_t;

  // (4096 - raw) * 100 / 4096
  function automatic logic [PCT_W-1:0] light_pct(input logic [RAW_W-1:0] raw);
    logic [12:0] inv;
    logic [18:0] prod;
    inv = 13'd4096 - {1'b0, raw};
    prod = {6'd0, inv} * 19'd100;
    return prod[18:12];
  endfunction

  // raw * 100 / 4096
  function automatic logic [PCT_W-1:0] rain_pct(input logic [RAW_W-1:0] raw);
    logic [18:0] prod;
    prod = {7'd0, raw} * 19'd100;
    return prod[18:12];
  endfunction

  // forward when hi side leads by more than the deadband, reverse when lo side does
  function automatic mode_t pair_mode(input logic [PCT_W-1:0] lo_side,
                                      input logic [PCT_W-1:0] hi_side);
    mode_t m;
    m = MODE_STOP;
    if (lo_side < hi_side && (hi_side - lo_side) > DEADBAND) begin
      m = MODE_FWD;
    end else if (lo_side > hi_side && (lo_side - hi_side) > DEADBAND) begin
      m = MODE_REV;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dalt_regs.sv
`default_nettype none
module dalt_regs (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [dalt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [dalt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dalt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output dalt_pkg::cfg_t                      cfg
);

  logic [dalt_pkg::THR_W-1:0] light_thr_r;
  logic [dalt_pkg::THR_W-1:0] rain_thr_r;
  logic [dalt_pkg::POS_W-1:0] limit_r;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_thr_r <= dalt_pkg::LIGHT_THR_RST;
      rain_thr_r  <= dalt_pkg::RAIN_THR_RST;
      limit_r     <= dalt_pkg::TRAVEL_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        dalt_pkg::REG_LIGHT_THR:    light_thr_r <= pwdata[dalt_pkg::THR_W-1:0];
        dalt_pkg::REG_RAIN_THR:     rain_thr_r  <= pwdata[dalt_pkg::THR_W-1:0];
        dalt_pkg::REG_TRAVEL_LIMIT: limit_r     <= pwdata[dalt_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      dalt_pkg::REG_LIGHT_THR:    prdata = {25'd0, light_thr_r};
      dalt_pkg::REG_RAIN_THR:     prdata = {25'd0, rain_thr_r};
      dalt_pkg::REG_TRAVEL_LIMIT: prdata = {24'd0, limit_r};
      default:                    prdata = '0;
    endcase
  end

  assign cfg.light_thr    = light_thr_r;
  assign cfg.rain_thr     = rain_thr_r;
  assign cfg.travel_limit = limit_r;

endmodule
`default_nettype wire

>>> rtl/dalt_decide.sv
`default_nettype none
module dalt_decide (
  input  wire  [dalt_pkg::RAW_W-1:0] left_raw,
  input  wire  [dalt_pkg::RAW_W-1:0] right_raw,
  input  wire  [dalt_pkg::RAW_W-1:0] up_raw,
  input  wire  [dalt_pkg::RAW_W-1:0] down_raw,
  input  wire  [dalt_pkg::RAW_W-1:0] rain_raw,
  input  dalt_pkg::cfg_t             cfg,
  output dalt_pkg::dec_t             dec
);

  logic [dalt_pkg::PCT_W-1:0] lp, rp, upp, dp, rain;
  logic                       halt;

  // scale readings to percent
  assign lp   = dalt_pkg::light_pct(left_raw);
  assign rp   = dalt_pkg::light_pct(right_raw);
  assign upp  = dalt_pkg::light_pct(up_raw);
  assign dp   = dalt_pkg::light_pct(down_raw);
  assign rain = dalt_pkg::rain_pct(rain_raw);

  // stop on rain or when every sensor is dark
  assign halt = (rain > cfg.rain_thr) ||
                (lp < cfg.light_thr && rp < cfg.light_thr &&
                 upp < cfg.light_thr && dp < cfg.light_thr);

  always_comb begin
    dec.left_pct  = lp;
    dec.right_pct = rp;
    dec.up_pct    = upp;
    dec.down_pct  = dp;
    if (halt) begin
      dec.horiz_mode = dalt_pkg::MODE_STOP;
      dec.vert_mode  = dalt_pkg::MODE_STOP;
    end else begin
      dec.horiz_mode = dalt_pkg::pair_mode(lp, rp);
      dec.vert_mode  = dalt_pkg::pair_mode(upp, dp);
    end
  end

endmodule
`default_nettype wire

>>> rtl/dalt_axis.sv
`default_nettype none
module dalt_axis #(
  parameter int PHASES_PER_COUNT = dalt_pkg::PHASES_PER_COUNT_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        fire,
  input  wire                        is_tick,
  input  dalt_pkg::mode_t            sample_mode,
  input  wire  [dalt_pkg::POS_W-1:0] travel_limit,
  output dalt_pkg::axis_res_t        res
);

  dalt_pkg::mode_t             mode_r, mode_nxt;
  logic [dalt_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [dalt_pkg::POS_W-1:0]  count_r, count_nxt;
  logic                        can_move;
  logic [dalt_pkg::STEP_W:0]   step_inc;
  logic                        wrap;

  // limit check for the current mode
  always_comb begin
    case (mode_r)
      dalt_pkg::MODE_FWD: can_move = count_r < travel_limit;
      dalt_pkg::MODE_REV: can_move = count_r != '0;
      default:            can_move = 1'b0;
    endcase
  end

  assign step_inc = {1'b0, step_r} + 4'd1;
  assign wrap     = step_inc >= 4'(PHASES_PER_COUNT);

  // next state and result word
  always_comb begin
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    res.drive = dalt_pkg::MODE_STOP;
    res.phase = '0;
    if (!is_tick) begin
      mode_nxt = sample_mode;
    end else if (can_move) begin
      step_nxt = wrap ? '0 : step_inc[dalt_pkg::STEP_W-1:0];
      if (wrap) begin
        count_nxt = (mode_r == dalt_pkg::MODE_FWD) ? count_r + 8'd1 : count_r - 8'd1;
      end
      res.drive = mode_r;
      res.phase = step_nxt;
    end
    res.mode = mode_nxt;
    res.pos  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= dalt_pkg::MODE_STOP;
      step_r  <= '0;
      count_r <= dalt_pkg::POS_RST;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dual_axis_light_tracker_stepper.sv
`default_nettype none
// channel   handshake                    payload
// in        in_valid / in_stall          in_opcode, in_*_raw
// out       out_valid / out_stall        out_*_cmd, out_*_drive, out_*_phase,
//                                        out_*_pos, out_*_pct
// cfg       psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One word per cycle sustained while out_stall is low; a word passes the input register, then
// the result register, the axis state updating at the same edge as the result register.
// Synchronous active-low reset clears both valid flags and returns the axis state
// and the configuration registers to their reset values. in_stall rises only when
// the input register holds a word and the result register is full and stalled.
module dual_axis_light_tracker_stepper #(
  parameter int PHASES_PER_COUNT = dalt_pkg::PHASES_PER_COUNT_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_opcode,
  input  wire  [dalt_pkg::RAW_W-1:0]          in_left_raw,
  input  wire  [dalt_pkg::RAW_W-1:0]          in_right_raw,
  input  wire  [dalt_pkg::RAW_W-1:0]          in_up_raw,
  input  wire  [dalt_pkg::RAW_W-1:0]          in_down_raw,
  input  wire  [dalt_pkg::RAW_W-1:0]          in_rain_raw,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_horiz_cmd,
  output logic [1:0]                          out_vert_cmd,
  output logic [1:0]                          out_horiz_drive,
  output logic [dalt_pkg::STEP_W-1:0]         out_horiz_phase,
  output logic [dalt_pkg::POS_W-1:0]          out_horiz_pos,
  output logic [1:0]                          out_vert_drive,
  output logic [dalt_pkg::STEP_W-1:0]         out_vert_phase,
  output logic [dalt_pkg::POS_W-1:0]          out_vert_pos,
  output logic [dalt_pkg::PCT_W-1:0]          out_left_pct,
  output logic [dalt_pkg::PCT_W-1:0]          out_right_pct,
  output logic [dalt_pkg::PCT_W-1:0]          out_up_pct,
  output logic [dalt_pkg::PCT_W-1:0]          out_down_pct,
  // configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [dalt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [dalt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dalt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  dalt_pkg::cfg_t      cfg;
  dalt_pkg::dec_t      dec;
  dalt_pkg::axis_res_t h_res, v_res;

  logic                       s1_valid_r;
  logic                       s1_op_r;
  logic [dalt_pkg::RAW_W-1:0] s1_left_r, s1_right_r, s1_up_r, s1_down_r, s1_rain_r;
  logic                       s1_go, in_acc, is_tick;

  logic                       out_valid_r;
  dalt_pkg::mode_t            o_hcmd_r, o_vcmd_r, o_hdrv_r, o_vdrv_r;
  logic [dalt_pkg::STEP_W-1:0] o_hph_r, o_vph_r;
  logic [dalt_pkg::POS_W-1:0] o_hpos_r, o_vpos_r;
  logic [dalt_pkg::PCT_W-1:0] o_lp_r, o_rp_r, o_up_r, o_dp_r;

  dalt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: the input register moves on whenever the result register frees up
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign is_tick  = s1_op_r == dalt_pkg::OP_TICK;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_opcode;
      s1_left_r  <= in_left_raw;
      s1_right_r <= in_right_raw;
      s1_up_r    <= in_up_raw;
      s1_down_r  <= in_down_raw;
      s1_rain_r  <= in_rain_raw;
    end
  end

  dalt_decide u_decide (
    .left_raw  (s1_left_r),
    .right_raw (s1_right_r),
    .up_raw    (s1_up_r),
    .down_raw  (s1_down_r),
    .rain_raw  (s1_rain_r),
    .cfg       (cfg),
    .dec       (dec)
  );

  dalt_axis #(.PHASES_PER_COUNT(PHASES_PER_COUNT)) u_axis_h (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_go),
    .is_tick      (is_tick),
    .sample_mode  (dec.horiz_mode),
    .travel_limit (cfg.travel_limit),
    .res          (h_res)
  );

  dalt_axis #(.PHASES_PER_COUNT(PHASES_PER_COUNT)) u_axis_v (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_go),
    .is_tick      (is_tick),
    .sample_mode  (dec.vert_mode),
    .travel_limit (cfg.travel_limit),
    .res          (v_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      o_hcmd_r <= h_res.mode;
      o_vcmd_r <= v_res.mode;
      o_hdrv_r <= h_res.drive;
      o_vdrv_r <= v_res.drive;
      o_hph_r  <= h_res.phase;
      o_vph_r  <= v_res.phase;
      o_hpos_r <= h_res.pos;
      o_vpos_r <= v_res.pos;
      o_lp_r   <= is_tick ? '0 : dec.left_pct;
      o_rp_r   <= is_tick ? '0 : dec.right_pct;
      o_up_r   <= is_tick ? '0 : dec.up_pct;
      o_dp_r   <= is_tick ? '0 : dec.down_pct;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_horiz_cmd   = o_hcmd_r;
  assign out_vert_cmd    = o_vcmd_r;
  assign out_horiz_drive = o_hdrv_r;
  assign out_horiz_phase = o_hph_r;
  assign out_horiz_pos   = o_hpos_r;
  assign out_vert_drive  = o_vdrv_r;
  assign out_vert_phase  = o_vph_r;
  assign out_vert_pos    = o_vpos_r;
  assign out_left_pct    = o_lp_r;
  assign out_right_pct   = o_rp_r;
  assign out_up_pct      = o_up_r;
  assign out_down_pct    = o_dp_r;

endmodule
`default_nettype wire

>>> tb/dual_axis_light_tracker_stepper_tb.sv
`timescale 1ns / 100ps

module dual_axis_light_tracker_stepper_tb;
  import dalt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 10;

  // one input word as the sender sees it
  typedef struct packed {
    logic             op;
    logic [RAW_W-1:0] left;
    logic [RAW_W-1:0] right;
    logic [RAW_W-1:0] up;
    logic [RAW_W-1:0] down;
    logic [RAW_W-1:0] rain;
  } sens_word_t;

  // one result word
  typedef struct packed {
    mode_t             h_cmd;
    mode_t             v_cmd;
    mode_t             h_drive;
    logic [STEP_W-1:0] h_phase;
    logic [POS_W-1:0]  h_pos;
    mode_t             v_drive;
    logic [STEP_W-1:0] v_phase;
    logic [POS_W-1:0]  v_pos;
    logic [PCT_W-1:0]  l_pct;
    logic [PCT_W-1:0]  r_pct;
    logic [PCT_W-1:0]  u_pct;
    logic [PCT_W-1:0]  d_pct;
  } track_res_t;

  // per-axis motor state plus what the last tick drove
  typedef struct packed {
    mode_t             mode;
    logic [STEP_W-1:0] step;
    logic [POS_W-1:0]  pos;
    mode_t             drive;
    logic [STEP_W-1:0] phase;
  } axis_st_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  sens_word_t in_word = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_horiz_cmd;
  logic [1:0]            out_vert_cmd;
  logic [1:0]            out_horiz_drive;
  logic [STEP_W-1:0]     out_horiz_phase;
  logic [POS_W-1:0]      out_horiz_pos;
  logic [1:0]            out_vert_drive;
  logic [STEP_W-1:0]     out_vert_phase;
  logic [POS_W-1:0]      out_vert_pos;
  logic [PCT_W-1:0]      out_left_pct;
  logic [PCT_W-1:0]      out_right_pct;
  logic [PCT_W-1:0]      out_up_pct;
  logic [PCT_W-1:0]      out_down_pct;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // tracker model state and its copy of the registers
  logic [THR_W-1:0] thr_light = LIGHT_THR_RST;
  logic [THR_W-1:0] thr_rain = RAIN_THR_RST;
  logic [POS_W-1:0] lim_travel = TRAVEL_LIMIT_RST;
  axis_st_t         h_ax;
  axis_st_t         v_ax;

  sens_word_t pend_q[$];
  track_res_t exp_q[$];

  // sequencing and idling controls
  int idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int in_gap = 0;
  int out_gap = 0;
  int words_queued = 0;
  int words_checked = 0;
  int n_errors = 0;
  int cycle_count = 0;

  // coverage tallies
  int n_samples = 0;
  int n_ticks = 0;
  int n_halted = 0;
  int n_stepped = 0;
  int n_blocked = 0;
  int n_cfg = 0;

  dual_axis_light_tracker_stepper u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_word.op),
    .in_left_raw     (in_word.left),
    .in_right_raw    (in_word.right),
    .in_up_raw       (in_word.up),
    .in_down_raw     (in_word.down),
    .in_rain_raw     (in_word.rain),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_horiz_cmd   (out_horiz_cmd),
    .out_vert_cmd    (out_vert_cmd),
    .out_horiz_drive (out_horiz_drive),
    .out_horiz_phase (out_horiz_phase),
    .out_horiz_pos   (out_horiz_pos),
    .out_vert_drive  (out_vert_drive),
    .out_vert_phase  (out_vert_phase),
    .out_vert_pos    (out_vert_pos),
    .out_left_pct    (out_left_pct),
    .out_right_pct   (out_right_pct),
    .out_up_pct      (out_up_pct),
    .out_down_pct    (out_down_pct),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic int pct_of_light(input logic [RAW_W-1:0] raw);
    return ((4096 - int'(raw)) * 100) / 4096;
  endfunction

  function automatic int pct_of_rain(input logic [RAW_W-1:0] raw);
    return (int'(raw) * 100) / 4096;
  endfunction

  // forward when the second sensor leads by more than the deadband, reverse when the first does
  function automatic mode_t lean_mode(input int lo_side, input int hi_side);
    if (lo_side < hi_side && hi_side - lo_side > 10) return MODE_FWD;
    if (lo_side > hi_side && lo_side - hi_side > 10) return MODE_REV;
    return MODE_STOP;
  endfunction

  // one motor tick on one axis
  function automatic axis_st_t axis_next(input axis_st_t a);
    axis_st_t n;
    int nxt;
    bit go;
    n = a;
    n.drive = MODE_STOP;
    n.phase = '0;
    case (a.mode)
      MODE_FWD: go = (a.pos < lim_travel);
      MODE_REV: go = (a.pos != '0);
      default:  go = 1'b0;
    endcase
    if (!go) begin
      if (a.mode != MODE_STOP) n_blocked++;
      return n;
    end
    n_stepped++;
    nxt = int'(a.step) + 1;
    // position moves once per full phase cycle
    if (nxt >= PHASES_PER_COUNT_DEF) begin
      nxt = 0;
      n.pos = (a.mode == MODE_FWD) ? a.pos + 8'd1 : a.pos - 8'd1;
    end
    n.step = nxt[STEP_W-1:0];
    n.phase = n.step;
    n.drive = a.mode;
    return n;
  endfunction

  function automatic track_res_t track_predict(input sens_word_t w);
    track_res_t r;
    int lp, rp, upp, dp, rain;
    r = '0;
    if (w.op == OP_SAMPLE) begin
      n_samples++;
      lp = pct_of_light(w.left);
      rp = pct_of_light(w.right);
      upp = pct_of_light(w.up);
      dp = pct_of_light(w.down);
      rain = pct_of_rain(w.rain);
      // rain or darkness parks both axes
      if (rain > int'(thr_rain) || (lp < int'(thr_light) && rp < int'(thr_light) &&
          upp < int'(thr_light) && dp < int'(thr_light))) begin
        h_ax.mode = MODE_STOP;
        v_ax.mode = MODE_STOP;
        n_halted++;
      end else begin
        v_ax.mode = lean_mode(upp, dp);
        h_ax.mode = lean_mode(lp, rp);
      end
      r.l_pct = lp[PCT_W-1:0];
      r.r_pct = rp[PCT_W-1:0];
      r.u_pct = upp[PCT_W-1:0];
      r.d_pct = dp[PCT_W-1:0];
    end else begin
      n_ticks++;
      h_ax = axis_next(h_ax);
      v_ax = axis_next(v_ax);
      r.h_drive = h_ax.drive;
      r.h_phase = h_ax.phase;
      r.v_drive = v_ax.drive;
      r.v_phase = v_ax.phase;
    end
    r.h_cmd = h_ax.mode;
    r.v_cmd = v_ax.mode;
    r.h_pos = h_ax.pos;
    r.v_pos = v_ax.pos;
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus

  // random light raw that scales to exactly p percent
  function automatic logic [RAW_W-1:0] raw_in_pct(input int p);
    int lo, hi, r;
    hi = 4096 - (p * 4096 + 99) / 100;
    lo = 4096 - ((p + 1) * 4096 + 99) / 100 + 1;
    if (hi > 4095) hi = 4095;
    if (lo < 0) lo = 0;
    r = $urandom_range(hi, lo);
    return r[RAW_W-1:0];
  endfunction

  // random rain raw that scales to exactly q percent
  function automatic logic [RAW_W-1:0] rain_in_pct(input int q);
    int lo, hi, r;
    lo = (q * 4096 + 99) / 100;
    hi = ((q + 1) * 4096 + 99) / 100 - 1;
    if (hi > 4095) hi = 4095;
    r = $urandom_range(hi, lo);
    return r[RAW_W-1:0];
  endfunction

  function automatic sens_word_t sample_of(input int l, input int r, input int u,
                                           input int d, input int rain_p);
    sens_word_t w;
    w.op = OP_SAMPLE;
    w.left = raw_in_pct(l);
    w.right = raw_in_pct(r);
    w.up = raw_in_pct(u);
    w.down = raw_in_pct(d);
    w.rain = rain_in_pct(rain_p);
    return w;
  endfunction

  function automatic sens_word_t any_word(input logic op);
    sens_word_t w;
    w.op = op;
    w.left = RAW_W'($urandom_range(4095, 0));
    w.right = RAW_W'($urandom_range(4095, 0));
    w.up = RAW_W'($urandom_range(4095, 0));
    w.down = RAW_W'($urandom_range(4095, 0));
    w.rain = RAW_W'($urandom_range(4095, 0));
    return w;
  endfunction

  // percent pair {first, second} that leans toward the given mode
  function automatic logic [2*PCT_W-1:0] pct_pair(input mode_t aim);
    int a, b, j;
    case (aim)
      MODE_FWD: begin
        b = $urandom_range(100, 40);
        a = $urandom_range(b - 11, 0);
      end
      MODE_REV: begin
        a = $urandom_range(100, 40);
        b = $urandom_range(a - 11, 0);
      end
      default: begin
        a = $urandom_range(100, 0);
        j = $urandom_range(20, 0);
        b = a + j - 10;
        if (b < 0) b = 0;
        if (b > 100) b = 100;
      end
    endcase
    return {a[PCT_W-1:0], b[PCT_W-1:0]};
  endfunction

  function automatic sens_word_t aimed_word(input mode_t ha, input mode_t va,
                                            input int rain_ok_pct);
    sens_word_t w;
    logic [2*PCT_W-1:0] hp, vp;
    int cap;
    hp = pct_pair(ha);
    vp = pct_pair(va);
    w.op = OP_SAMPLE;
    w.left = raw_in_pct(int'(hp[2*PCT_W-1:PCT_W]));
    w.right = raw_in_pct(int'(hp[PCT_W-1:0]));
    w.up = raw_in_pct(int'(vp[2*PCT_W-1:PCT_W]));
    w.down = raw_in_pct(int'(vp[PCT_W-1:0]));
    // largest raw still at or under the rain threshold
    cap = ((int'(thr_rain) + 1) * 4096 + 99) / 100 - 1;
    if (cap > 4095) cap = 4095;
    if ($urandom_range(99, 0) < rain_ok_pct) w.rain = RAW_W'($urandom_range(cap, 0));
    else w.rain = RAW_W'($urandom_range(4095, 0));
    return w;
  endfunction

  task automatic enqueue(input sens_word_t w);
    pend_q.push_back(w);
    words_queued++;
  endtask

  task automatic run_phase(input int n, input int tick_pct, input int aim_pct,
                           input int rain_ok_pct, input bit fixed_aim,
                           input mode_t ha, input mode_t va);
    mode_t h, v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < tick_pct) begin
        enqueue(any_word(OP_TICK));
      end else if ($urandom_range(99, 0) < aim_pct) begin
        h = fixed_aim ? ha : mode_t'($urandom_range(2, 0));
        v = fixed_aim ? va : mode_t'($urandom_range(2, 0));
        enqueue(aimed_word(h, v, rain_ok_pct));
      end else begin
        enqueue(any_word(OP_SAMPLE));
      end
    end
  endtask

  // control changes land between clock edges
  task automatic phase_setup(input int idle, input bit long_hold);
    @(negedge clk);
    idle_pct = idle;
    if (long_hold) hold_asks++;
  endtask

  // wait until every queued word has come back, then let the pipe empty
  task automatic settle();
    while (words_checked < words_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LIGHT_THR:    thr_light = val[THR_W-1:0];
      REG_RAIN_THR:     thr_rain = val[THR_W-1:0];
      REG_TRAVEL_LIMIT: lim_travel = val[POS_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_regs(input int light, input int rain, input int limit);
    reg_write(REG_LIGHT_THR, light);
    reg_write(REG_RAIN_THR, rain);
    reg_write(REG_TRAVEL_LIMIT, limit);
  endtask

  // ---------------------------------------------------------------- sender

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        exp_q.push_back(track_predict(in_word));
      end
      // a stalled word stays put
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        in_gap <= $urandom_range(5, 0);
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_word <= pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      out_gap <= $urandom_range(5, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void match_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    track_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        e = exp_q.pop_front();
        match_field("horiz_cmd", 8'(e.h_cmd), 8'(out_horiz_cmd));
        match_field("vert_cmd", 8'(e.v_cmd), 8'(out_vert_cmd));
        match_field("horiz_drive", 8'(e.h_drive), 8'(out_horiz_drive));
        match_field("horiz_phase", 8'(e.h_phase), 8'(out_horiz_phase));
        match_field("horiz_pos", e.h_pos, out_horiz_pos);
        match_field("vert_drive", 8'(e.v_drive), 8'(out_vert_drive));
        match_field("vert_phase", 8'(e.v_phase), 8'(out_vert_phase));
        match_field("vert_pos", e.v_pos, out_vert_pos);
        match_field("left_pct", 8'(e.l_pct), 8'(out_left_pct));
        match_field("right_pct", 8'(e.r_pct), 8'(out_right_pct));
        match_field("up_pct", 8'(e.u_pct), 8'(out_up_pct));
        match_field("down_pct", 8'(e.d_pct), 8'(out_down_pct));
        words_checked++;
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------- sequence

  initial begin
    h_ax = '0;
    h_ax.pos = POS_RST;
    v_ax = '0;
    v_ax.pos = POS_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, field extremes, deadband and threshold edges
    phase_setup(15, 1'b0);
    enqueue(any_word(OP_TICK));
    enqueue(sample_of(100, 100, 100, 100, 0));
    enqueue(sample_of(0, 0, 0, 0, 0));
    enqueue(sample_of(100, 0, 0, 100, 0));
    repeat (9) enqueue(any_word(OP_TICK));
    enqueue(sample_of(50, 60, 60, 50, 30));
    enqueue(sample_of(50, 61, 61, 50, 30));
    enqueue(any_word(OP_TICK));
    enqueue(sample_of(50, 61, 61, 50, 31));
    enqueue(any_word(OP_TICK));
    enqueue(sample_of(19, 19, 19, 19, 0));
    enqueue(sample_of(20, 9, 19, 19, 0));
    enqueue(any_word(OP_TICK));
    enqueue(sample_of(0, 0, 0, 0, 99));
    settle();

    // drive both axes home to zero
    set_regs(int'(LIGHT_THR_RST), int'(RAIN_THR_RST), int'(TRAVEL_LIMIT_RST));
    phase_setup(10, 1'b0);
    run_phase(1000, 92, 97, 100, 1'b1, MODE_REV, MODE_REV);
    settle();

    // zero travel limit blocks forward at home
    set_regs(int'(LIGHT_THR_RST), int'(RAIN_THR_RST), 0);
    phase_setup(0, 1'b0);
    run_phase(60, 70, 95, 100, 1'b1, MODE_FWD, MODE_FWD);
    settle();

    // limit of one: a few steps then coils off
    set_regs(int'(LIGHT_THR_RST), int'(RAIN_THR_RST), 1);
    phase_setup(20, 1'b0);
    run_phase(80, 75, 90, 100, 1'b1, MODE_FWD, MODE_FWD);
    settle();

    // loosest thresholds, widest travel
    set_regs(0, 99, 255);
    phase_setup(25, 1'b0);
    run_phase(150, 50, 50, 80, 1'b0, MODE_STOP, MODE_STOP);
    settle();

    // strictest thresholds
    set_regs(99, 0, 128);
    phase_setup(20, 1'b0);
    run_phase(100, 50, 50, 80, 1'b0, MODE_STOP, MODE_STOP);
    settle();

    // long receiver hold with the sender still pushing
    set_regs(45, 60, 255);
    phase_setup(15, 1'b1);
    run_phase(150, 50, 70, 80, 1'b0, MODE_STOP, MODE_STOP);
    settle();

    // random registers, sender pauses mid-phase until all results are back
    set_regs($urandom_range(99, 0), $urandom_range(99, 0), $urandom_range(255, 1));
    phase_setup(30, 1'b0);
    run_phase(80, 60, 70, 80, 1'b0, MODE_STOP, MODE_STOP);
    settle();
    set_regs(10, 50, 150);
    run_phase(60, 60, 70, 80, 1'b0, MODE_STOP, MODE_STOP);
    while (words_checked < words_queued) @(posedge clk);
    run_phase(60, 60, 70, 80, 1'b0, MODE_STOP, MODE_STOP);
    settle();

    // back to reset values, full rate on both sides
    set_regs(int'(LIGHT_THR_RST), int'(RAIN_THR_RST), int'(TRAVEL_LIMIT_RST));
    phase_setup(0, 1'b0);
    run_phase(80, 50, 70, 80, 1'b0, MODE_STOP, MODE_STOP);
    while (words_checked < words_queued) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (exp_q.size() != 0) begin
      $error("%0d expected result words never arrived", exp_q.size());
      n_errors++;
    end
    $display("covered %0d samples (%0d forced stops) and %0d ticks over %0d register writes",
             n_samples, n_halted, n_ticks, n_cfg);
    $display("axes stepped %0d times and were held at a travel end %0d times",
             n_stepped, n_blocked);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dalt_pkg.sv
rtl/dalt_regs.sv
rtl/dalt_decide.sv
rtl/dalt_axis.sv
rtl/dual_axis_light_tracker_stepper.sv
tb/dual_axis_light_tracker_stepper_tb.sv
